[rtl/rigk_pkg.sv]
package rigk_pkg;

    localparam int unsigned CFG_W = 5;

    typedef struct packed {
        logic signed [31:0] value;
        logic               end_in;
    } in_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               run_last;
        logic               sequence_done;
    } out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic rd_issue;
        logic advance;
    } cmd_t;

    typedef struct packed {
        logic emit;
        logic last;
    } status_t;

endpackage

[rtl/rigk_ram.sv]
module rigk_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/rigk_ctrl.sv]
module rigk_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  rigk_pkg::status_t status,
    output rigk_pkg::cmd_t    cmd
);

    rigk_pkg::state_t state_reg;
    rigk_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rigk_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_stall     = 1'b1;
        out_valid    = 1'b0;
        cmd.accept   = 1'b0;
        cmd.rd_issue = 1'b0;
        cmd.advance  = 1'b0;
        unique case (state_reg)
            rigk_pkg::ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
                if (in_valid && status.emit)
                begin
                    state_next = rigk_pkg::ST_READ;
                end
            end
            rigk_pkg::ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = rigk_pkg::ST_OUT;
            end
            rigk_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    if (status.last)
                    begin
                        state_next = rigk_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = rigk_pkg::ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = rigk_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/rigk_dp.sv]
module rigk_dp #(
    parameter int unsigned MAX_GROUP = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rigk_pkg::CFG_W-1:0]     cfg_data,
    input  rigk_pkg::in_t                  in_data,
    output rigk_pkg::out_t                 out_data,
    input  rigk_pkg::cmd_t                 cmd,
    output rigk_pkg::status_t              status
);

    localparam int unsigned AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int unsigned CW = $clog2(MAX_GROUP + 1);
    localparam int unsigned KW = (CW > rigk_pkg::CFG_W) ? CW : rigk_pkg::CFG_W;

    logic [rigk_pkg::CFG_W-1:0] gsize_reg;
    logic [CW-1:0]              fill_reg;
    logic [CW-1:0]              n_reg;
    logic [CW-1:0]              idx_reg;
    logic                       rev_reg;
    logic                       end_reg;

    logic [KW-1:0] gs_ext;
    logic [KW-1:0] k_eff;
    logic [CW-1:0] n_new;
    logic          full;
    logic [CW-1:0] rd_pos;
    logic [31:0]   rdata;

    assign gs_ext = KW'(gsize_reg);
    assign n_new  = fill_reg + CW'(1);

    always_comb
    begin
        priority if (gsize_reg == '0)
        begin
            k_eff = KW'(1);
        end
        else if (gs_ext > KW'(MAX_GROUP))
        begin
            k_eff = KW'(MAX_GROUP);
        end
        else
        begin
            k_eff = gs_ext;
        end
    end

    assign full        = KW'(n_new) >= k_eff;
    assign status.emit = full || in_data.end_in;
    assign status.last = (idx_reg + CW'(1)) == n_reg;
    assign rd_pos      = rev_reg ? (n_reg - CW'(1) - idx_reg) : idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gsize_reg <= rigk_pkg::CFG_W'(1);
            fill_reg  <= '0;
            n_reg     <= '0;
            idx_reg   <= '0;
            rev_reg   <= 1'b0;
            end_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                gsize_reg <= cfg_data;
            end
            if (cmd.accept)
            begin
                if (status.emit)
                begin
                    fill_reg <= '0;
                    n_reg    <= n_new;
                    idx_reg  <= '0;
                    rev_reg  <= full;
                    end_reg  <= in_data.end_in;
                end
                else
                begin
                    fill_reg <= n_new;
                end
            end
            if (cmd.advance)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
        end
    end

    rigk_ram #(
        .WIDTH(32),
        .DEPTH(MAX_GROUP)
    ) u_buf (
        .clk  (clk),
        .we   (cmd.accept),
        .waddr(fill_reg[AW-1:0]),
        .wdata(in_data.value),
        .re   (cmd.rd_issue),
        .raddr(rd_pos[AW-1:0]),
        .rdata(rdata)
    );

    assign out_data.result_value  = rdata;
    assign out_data.run_last      = status.last;
    assign out_data.sequence_done = status.last && end_reg;

endmodule

[rtl/reverse_in_groups_of_k.sv]
// Reorders a stream of signed 32-bit values in groups of group_size (1 to MAX_GROUP; 0 acts
// as 1 and larger values act as MAX_GROUP). A full group comes out reversed, and a partial
// group closed by end_in comes out in arrival order. The last result of each closing
// transaction carries run_last, and sequence_done as well when end_in was set. For a
// transaction that closes a group, each result is read back from the buffer memory and held
// in the memory's output register until it is taken, before the next read; no new input is
// taken until the last result has left. Write group_size only while the block is idle.
module reverse_in_groups_of_k #(
    parameter int unsigned MAX_GROUP = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  rigk_pkg::in_t              in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output rigk_pkg::out_t             out_data,
    input  logic                       cfg_we,
    input  logic [rigk_pkg::CFG_W-1:0] cfg_data
);

    rigk_pkg::cmd_t    cmd;
    rigk_pkg::status_t status;

    rigk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status   (status),
        .cmd      (cmd)
    );

    rigk_dp #(
        .MAX_GROUP(MAX_GROUP)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_we),
        .cfg_data(cfg_data),
        .in_data (in_data),
        .out_data(out_data),
        .cmd     (cmd),
        .status  (status)
    );

endmodule

[tb/reverse_in_groups_of_k_checker.sv]
module reverse_in_groups_of_k_checker #(
    parameter int unsigned MAX_GROUP = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  rigk_pkg::in_t              in_data,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  rigk_pkg::out_t             out_data,
    input  logic                       cfg_we,
    input  logic [rigk_pkg::CFG_W-1:0] cfg_data,
    output int                         mismatches,
    output int                         outstanding
);

    import rigk_pkg::*;

    logic signed [31:0] held_values [MAX_GROUP];
    int unsigned        open_count;
    logic [CFG_W-1:0]   group_len;
    out_t               expected_results [$];
    out_t               want;
    logic               bad;

    // A group closes once it holds at least group_len values (0 acts as 1, larger as MAX_GROUP);
    // a closing transaction with end_in set on a partial group flushes it in arrival order instead.
    task automatic reorder_value(input in_t t);
        int unsigned k;
        int unsigned n;
        out_t        r;
        k = (group_len == 0) ? 1 : ((group_len > MAX_GROUP) ? MAX_GROUP : group_len);
        if (open_count >= MAX_GROUP)
        begin
            open_count = MAX_GROUP - 1;
        end
        held_values[open_count] = t.value;
        open_count++;
        n = open_count;
        if (n >= k || t.end_in)
        begin
            for (int unsigned i = 0; i < n; i++)
            begin
                r.result_value  = (n >= k) ? held_values[n - 1 - i] : held_values[i];
                r.run_last      = (i + 1 == n);
                r.sequence_done = (i + 1 == n) && t.end_in;
                expected_results.insert(expected_results.size(), r);
            end
            open_count = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_count = 0;
            group_len = CFG_W'(1);
            expected_results.delete();
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected transaction: result_value %0d", out_data.result_value);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    bad = 1'b0;
                    if (out_data.result_value !== want.result_value)
                    begin
                        $error("result_value: expected %0d, actual %0d",
                               want.result_value, out_data.result_value);
                        bad = 1'b1;
                    end
                    if (out_data.run_last !== want.run_last)
                    begin
                        $error("run_last: expected %0b, actual %0b",
                               want.run_last, out_data.run_last);
                        bad = 1'b1;
                    end
                    if (out_data.sequence_done !== want.sequence_done)
                    begin
                        $error("sequence_done: expected %0b, actual %0b",
                               want.sequence_done, out_data.sequence_done);
                        bad = 1'b1;
                    end
                    if (bad)
                    begin
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (cfg_we)
            begin
                group_len = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                reorder_value(in_data);
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

[tb/reverse_in_groups_of_k_tb.sv]
module reverse_in_groups_of_k_tb;

    import rigk_pkg::*;

    localparam int unsigned MAX_GROUP = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int BUSY_PCT = 67;
    localparam int BOTH_PCT = 23;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES = 12;
    localparam int ITEMS_PER_PHASE = 31;
    localparam logic signed [31:0] MOST_NEGATIVE = 32'sh8000_0000;
    localparam logic signed [31:0] MOST_POSITIVE = 32'sh7fff_ffff;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    in_t              in_data = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    out_t             out_data;
    logic             cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_data = '0;
    int               mismatches;
    int               outstanding;
    int               sender_idle_pct = 0;
    int               stall_pct = 0;
    int               cycle_count = 0;
    int               phase_sizes [10] = '{16, 1, 0, 31, 17, 5, 3, 2, 9, 12};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    reverse_in_groups_of_k #(
        .MAX_GROUP(MAX_GROUP)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    reverse_in_groups_of_k_checker #(
        .MAX_GROUP(MAX_GROUP)
    ) chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_value(input logic signed [31:0] v, input logic last);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{v, last};
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
    endtask

    // The extra cycles cover a transaction that closes no group and so shows no result.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (5) @(posedge clk);
    endtask

    task automatic set_group_size(input logic [CFG_W-1:0] v);
        cfg_data <= v;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(15))
            0: return MOST_NEGATIVE;
            1: return MOST_POSITIVE;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_value(MOST_NEGATIVE, 1'b0);
        push_value(MOST_POSITIVE, 1'b0);
        push_value(32'sd0, 1'b0);
        push_value(-32'sd1, 1'b1);
        drain();

        set_group_size(CFG_W'(4));
        for (int i = 1; i <= 4; i++)
        begin
            push_value(i, 1'b0);
        end
        push_value(5, 1'b0);
        push_value(6, 1'b1);
        for (int i = 7; i <= 10; i++)
        begin
            push_value(i, i == 10);
        end
        drain();

        // Shrinking the group while values are held closes it on the next transaction.
        set_group_size(CFG_W'(8));
        push_value(11, 1'b0);
        push_value(12, 1'b0);
        push_value(13, 1'b0);
        drain();
        set_group_size(CFG_W'(2));
        push_value(14, 1'b0);
        push_value(15, 1'b1);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            set_group_size(CFG_W'((p < 10) ? phase_sizes[p] : $urandom_range(31)));
            case (p % 4)
                0:
                begin
                    sender_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct = BUSY_PCT;
                    stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    stall_pct = BUSY_PCT;
                end
                default:
                begin
                    sender_idle_pct = BOTH_PCT;
                    stall_pct = BOTH_PCT;
                end
            endcase
            repeat (ITEMS_PER_PHASE) push_value(pick_value(), $urandom_range(7) == 0);
            drain();
        end

        sender_idle_pct = 0;
        stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
